/* hw/rtl/tpwm_pkg.sv */
package tpwm_pkg;

  // Default fractional width of the normalised values (Q17.14)
  localparam int unsigned FracBitsDef = 14;

  // Port widths fixed by the field definitions
  localparam int unsigned VoltW = 16;
  localparam int unsigned BusW  = 15;
  localparam int unsigned DutyW = 15;

  // cos(30 deg) in Q30, rounded to nearest at the working scale during elaboration
  localparam longint KQ30 = 64'sd929887697;

  typedef enum logic [2:0] {
    SCH_SPWM  = 3'd0,
    SCH_SVPWM = 3'd1,
    SCH_CMAX  = 3'd2,
    SCH_CMIN  = 3'd3,
    SCH_DPWM0 = 3'd4,
    SCH_DPWM1 = 3'd5,
    SCH_DPWM2 = 3'd6,
    SCH_DPWM3 = 3'd7
  } scheme_e;

  localparam scheme_e SchemeRst = SCH_SVPWM;

  // Pipeline control handed to the divider
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

/* hw/rtl/three_phase_pwm_duty_modulator_top.sv */
// Three-phase PWM duty modulator.
// Input channel: volt_alpha_i, volt_beta_i and bus_voltage_i with in_valid_i;
// a request is taken on a clock edge with in_valid_i high and in_stall_o low.
// Output channel: phase_a/b/c_duty_o with out_valid_o; a result leaves on an
// edge with out_valid_o high and out_stall_i low. Duty 2^FRAC_BITS is 100 %.
// Configuration: cfg_data_i[2:0] selects the modulation scheme, written when
// cfg_valid_i is high (cfg_ready_o is always high). Write it only while idle.
// The normalising divider registers each quotient bit in turn, then four
// arithmetic stages follow; the divider bit chain sets the depth.
// Throughput is one request per cycle while the pipeline is not frozen.
// While the output stage holds an untaken result and out_stall_i is high,
// the whole pipeline freezes and in_stall_o rises; nothing is lost.
// Reset empties the pipeline and selects SVPWM.
module three_phase_pwm_duty_modulator_top
  import tpwm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [2:0]              cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [VoltW-1:0] volt_alpha_i,
  input  logic signed [VoltW-1:0] volt_beta_i,
  input  logic [BusW-1:0]         bus_voltage_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [DutyW-1:0]        phase_a_duty_o,
  output logic [DutyW-1:0]        phase_b_duty_o,
  output logic [DutyW-1:0]        phase_c_duty_o
);

  localparam int unsigned NumW = VoltW + FRAC_BITS;
  localparam int unsigned PW   = NumW + 5;
  localparam logic [FRAC_BITS:0] KC =
    (FRAC_BITS+1)'((KQ30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
  localparam logic signed [PW-1:0] OneQ  = PW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] HalfQ = PW'(1) << (FRAC_BITS - 1);

  // Round half away from zero
  function automatic logic signed [PW-1:0] half_r(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] t;
    t = x + PW'(!x[PW-1]);
    return t >>> 1;
  endfunction

  function automatic logic signed [PW-1:0] mul_k(input logic signed [PW-1:0] x);
    logic [PW-1:0]         mag;
    logic [PW+FRAC_BITS:0] p;
    mag = x[PW-1] ? PW'(-x) : PW'(x);
    p   = ((PW+FRAC_BITS+1)'(mag) * (PW+FRAC_BITS+1)'(KC)
           + ((PW+FRAC_BITS+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x[PW-1] ? -$signed(p[PW-1:0]) : $signed(p[PW-1:0]);
  endfunction

  function automatic logic signed [PW-1:0] max3(input logic signed [PW-1:0] a,
                                                input logic signed [PW-1:0] b,
                                                input logic signed [PW-1:0] c);
    logic signed [PW-1:0] m;
    m = (a >= b) ? a : b;
    return (m >= c) ? m : c;
  endfunction

  function automatic logic signed [PW-1:0] min3(input logic signed [PW-1:0] a,
                                                input logic signed [PW-1:0] b,
                                                input logic signed [PW-1:0] c);
    logic signed [PW-1:0] m;
    m = (a <= b) ? a : b;
    return (m <= c) ? m : c;
  endfunction

  function automatic logic [DutyW-1:0] clip(input logic signed [PW-1:0] d);
    logic signed [PW-1:0] c;
    c = d;
    if (d < 0) c = '0;
    if (d > OneQ) c = OneQ;
    return c[DutyW-1:0];
  endfunction

  scheme_e   scheme_q;
  pipe_ctl_t ctl;
  logic      en;

  // Advance everything unless a held result is stalled
  assign en          = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;
  assign ctl         = '{en: en, vld: in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q <= SchemeRst;
    end else if (cfg_valid_i) begin
      scheme_q <= scheme_e'(cfg_data_i);
    end
  end

  // Normalise by the bus voltage
  logic                div_vld;
  logic signed [NumW:0] al_n, be_n;

  tpwm_div #(.FracBits(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .alpha_i (volt_alpha_i),
    .beta_i  (volt_beta_i),
    .bus_i   (bus_voltage_i),
    .valid_o (div_vld),
    .alpha_o (al_n),
    .beta_o  (be_n)
  );

  logic signed [PW-1:0] al_w, be_w;
  assign al_w = PW'(al_n);
  assign be_w = PW'(be_n);

  // Stage 1: scaled and halved components
  logic                 v1_q;
  logic signed [PW-1:0] al1_q, mka1_q, mkb1_q, ha1_q, hb1_q;
  // Stage 2: phase a/b and rotated vector
  logic                 v2_q;
  logic signed [PW-1:0] pa2_q, pb2_q, ra2_q, rb2_q;
  // Stage 3: all phases, extremes, rotated terms
  logic                 v3_q;
  logic signed [PW-1:0] pa3_q, pb3_q, pc3_q, mx3_q, mn3_q, ra3_q, hra3_q, mkrb3_q;
  // Stage 4: output register
  logic                 v4_q;
  logic [DutyW-1:0]     da_q, db_q, dc_q;

  logic signed [PW-1:0] ra2_d, rb2_d;
  always_comb begin
    unique case (scheme_q)
      SCH_DPWM0: begin
        ra2_d = mka1_q - hb1_q;
        rb2_d = ha1_q + mkb1_q;
      end
      SCH_DPWM2: begin
        ra2_d = mka1_q + hb1_q;
        rb2_d = -ha1_q + mkb1_q;
      end
      default: begin
        ra2_d = ha1_q + mkb1_q;
        rb2_d = -mka1_q + hb1_q;
      end
    endcase
  end

  logic signed [PW-1:0] pc3_d;
  assign pc3_d = -pa2_q - pb2_q;

  // Final stage: offset from the scheme, then clip
  logic signed [PW-1:0] q0, q1, q2, off, sum_mm, rsum;
  logic                 rtop;
  always_comb begin
    q0     = ra3_q;
    q1     = -hra3_q + mkrb3_q;
    q2     = -q0 - q1;
    rsum   = max3(q0, q1, q2) + min3(q0, q1, q2);
    rtop   = !rsum[PW-1];
    sum_mm = mx3_q + mn3_q;
    unique case (scheme_q)
      SCH_SPWM:  off = HalfQ;
      SCH_SVPWM: off = HalfQ - half_r(sum_mm);
      SCH_CMAX:  off = OneQ - mx3_q;
      SCH_CMIN:  off = -mn3_q;
      SCH_DPWM1: off = !sum_mm[PW-1] ? OneQ - mx3_q : -mn3_q;
      default:   off = rtop ? OneQ - mx3_q : -mn3_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= div_vld;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      al1_q   <= al_w;
      mka1_q  <= mul_k(al_w);
      mkb1_q  <= mul_k(be_w);
      ha1_q   <= half_r(al_w);
      hb1_q   <= half_r(be_w);
      pa2_q   <= al1_q;
      pb2_q   <= -ha1_q + mkb1_q;
      ra2_q   <= ra2_d;
      rb2_q   <= rb2_d;
      pa3_q   <= pa2_q;
      pb3_q   <= pb2_q;
      pc3_q   <= pc3_d;
      mx3_q   <= max3(pa2_q, pb2_q, pc3_d);
      mn3_q   <= min3(pa2_q, pb2_q, pc3_d);
      ra3_q   <= ra2_q;
      hra3_q  <= half_r(ra2_q);
      mkrb3_q <= mul_k(rb2_q);
      da_q    <= clip(pa3_q + off);
      db_q    <= clip(pb3_q + off);
      dc_q    <= clip(pc3_q + off);
    end
  end

  assign out_valid_o    = v4_q;
  assign phase_a_duty_o = da_q;
  assign phase_b_duty_o = db_q;
  assign phase_c_duty_o = dc_q;

  // Checks
  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_phase_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (pa3_q + pb3_q + pc3_q) == '0)
    else $error("phase references do not sum to zero");

  a_extremes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (mx3_q >= mn3_q))
    else $error("phase maximum below minimum");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v3_q) && $stable(pa3_q)))
    else $error("pipeline moved while stalled");

endmodule

/* hw/rtl/tpwm_div.sv */
module tpwm_div
  import tpwm_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef,
  localparam int unsigned NumW = VoltW + FracBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pipe_ctl_t              ctl_i,
  input  logic signed [VoltW-1:0] alpha_i,
  input  logic signed [VoltW-1:0] beta_i,
  input  logic [BusW-1:0]        bus_i,
  output logic                   valid_o,
  output logic signed [NumW:0]   alpha_o,
  output logic signed [NumW:0]   beta_o
);

  // Restoring division, one quotient bit per stage, both lanes share the divisor
  logic [BusW-1:0] rem_q [NumW][2];
  logic [NumW-1:0] wk_q  [NumW][2];
  logic            neg_q [NumW][2];
  logic [BusW-1:0] bus_q [NumW];
  logic            vld_q [NumW];

  logic [BusW-1:0]  bus_eff;
  logic [VoltW-1:0] mag [2];
  logic [NumW-1:0]  num [2];
  logic             sgn [2];

  // Take magnitudes and add half the divisor for round to nearest
  always_comb begin
    bus_eff = (bus_i == '0) ? BusW'(1) : bus_i;
    sgn[0]  = alpha_i[VoltW-1];
    sgn[1]  = beta_i[VoltW-1];
    mag[0]  = sgn[0] ? VoltW'(-alpha_i) : VoltW'(alpha_i);
    mag[1]  = sgn[1] ? VoltW'(-beta_i) : VoltW'(beta_i);
    for (int l = 0; l < 2; l++) begin
      num[l] = {mag[l], {FracBits{1'b0}}} + NumW'(bus_eff >> 1);
    end
  end

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [BusW-1:0] rem_in [2];
    logic [NumW-1:0] wk_in  [2];
    logic            neg_in [2];
    logic [BusW-1:0] bus_in;
    logic            vld_in;
    logic [BusW:0]   trial  [2];
    logic            ge     [2];

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          rem_in[l] = '0;
          wk_in[l]  = num[l];
          neg_in[l] = sgn[l];
        end
        bus_in = bus_eff;
        vld_in = ctl_i.vld;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          rem_in[l] = rem_q[k-1][l];
          wk_in[l]  = wk_q[k-1][l];
          neg_in[l] = neg_q[k-1][l];
        end
        bus_in = bus_q[k-1];
        vld_in = vld_q[k-1];
      end
    end

    // Shift in the next dividend bit and try a subtract
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {rem_in[l], wk_in[l][NumW-1]};
        ge[l]    = trial[l] >= {1'b0, bus_in};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        for (int l = 0; l < 2; l++) begin
          rem_q[k][l] <= ge[l] ? BusW'(trial[l] - {1'b0, bus_in}) : trial[l][BusW-1:0];
          wk_q[k][l]  <= {wk_in[l][NumW-2:0], ge[l]};
          neg_q[k][l] <= neg_in[l];
        end
        bus_q[k] <= bus_in;
      end
    end
  end

  // Restore the signs
  assign valid_o = vld_q[NumW-1];
  assign alpha_o = neg_q[NumW-1][0] ? -$signed({1'b0, wk_q[NumW-1][0]})
                                    :  $signed({1'b0, wk_q[NumW-1][0]});
  assign beta_o  = neg_q[NumW-1][1] ? -$signed({1'b0, wk_q[NumW-1][1]})
                                    :  $signed({1'b0, wk_q[NumW-1][1]});

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tpwm_pkg::*;

  localparam int unsigned Frac    = FracBitsDef;
  localparam longint      OneQ    = longint'(1) << Frac;
  localparam longint      HalfQ   = longint'(1) << (Frac - 1);
  localparam int unsigned Latency = 16 + Frac + 4;

  typedef struct {
    logic [DutyW-1:0] a;
    logic [DutyW-1:0] b;
    logic [DutyW-1:0] c;
  } duty_set_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [2:0]              cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [VoltW-1:0] volt_alpha_i = '0;
  logic signed [VoltW-1:0] volt_beta_i = '0;
  logic [BusW-1:0]         bus_voltage_i = 15'd1;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [DutyW-1:0]        phase_a_duty_o;
  logic [DutyW-1:0]        phase_b_duty_o;
  logic [DutyW-1:0]        phase_c_duty_o;

  scheme_e   scheme_q;
  duty_set_t duty_fifo[$];
  int        n_errors;
  int        n_duties;
  int        send_idle_pct;
  int        recv_idle_pct;

  three_phase_pwm_duty_modulator_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .volt_alpha_i  (volt_alpha_i),
    .volt_beta_i   (volt_beta_i),
    .bus_voltage_i (bus_voltage_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .phase_a_duty_o(phase_a_duty_o),
    .phase_b_duty_o(phase_b_duty_o),
    .phase_c_duty_o(phase_c_duty_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the pipeline hangs
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // Round-half-away helpers of the duty arithmetic
  function automatic longint halve(longint x);
    return x >= 0 ? (x + 1) / 2 : -((-x + 1) / 2);
  endfunction

  function automatic longint times_cos30(longint x);
    longint k;
    longint mag;
    longint p;
    k   = (KQ30 + (longint'(1) << (29 - Frac))) >>> (30 - Frac);
    mag = x >= 0 ? x : -x;
    p   = (mag * k + (longint'(1) << (Frac - 1))) >>> Frac;
    return x >= 0 ? p : -p;
  endfunction

  function automatic longint per_unit(longint v, longint bus);
    longint mag;
    longint q;
    mag = (v >= 0 ? v : -v) <<< Frac;
    q   = (mag + bus / 2) / bus;
    return v >= 0 ? q : -q;
  endfunction

  // Returns max + min of the three phase references
  function automatic longint phase_span(longint al, longint be);
    longint pa;
    longint pb;
    longint pc;
    longint mx;
    longint mn;
    pa = al;
    pb = -halve(al) + times_cos30(be);
    pc = -pa - pb;
    mx = pa > pb ? pa : pb;
    mx = mx > pc ? mx : pc;
    mn = pa < pb ? pa : pb;
    mn = mn < pc ? mn : pc;
    return mx + mn;
  endfunction

  // Clamp side after rotating the vector; 1 means clamp the top phase
  function automatic bit clamp_top_rotated(longint al, longint be, scheme_e sch);
    longint ra;
    longint rb;
    case (sch)
      SCH_DPWM0: begin
        ra = times_cos30(al) - halve(be);
        rb = halve(al) + times_cos30(be);
      end
      SCH_DPWM2: begin
        ra = times_cos30(al) + halve(be);
        rb = -halve(al) + times_cos30(be);
      end
      default: begin
        ra = halve(al) + times_cos30(be);
        rb = -times_cos30(al) + halve(be);
      end
    endcase
    return phase_span(ra, rb) >= 0;
  endfunction

  function automatic longint clip_duty(longint d);
    if (d < 0) return 0;
    if (d > OneQ) return OneQ;
    return d;
  endfunction

  function automatic duty_set_t predict_duties(logic signed [VoltW-1:0] va,
                                               logic signed [VoltW-1:0] vb,
                                               logic [BusW-1:0] bus_in,
                                               scheme_e sch);
    longint    bus;
    longint    al;
    longint    be;
    longint    ph[3];
    longint    mx;
    longint    mn;
    longint    off;
    duty_set_t r;
    bus = bus_in == 0 ? 1 : longint'(bus_in);
    al  = per_unit(longint'(va), bus);
    be  = per_unit(longint'(vb), bus);
    ph[0] = al;
    ph[1] = -halve(al) + times_cos30(be);
    ph[2] = -ph[0] - ph[1];
    mx = ph[0] > ph[1] ? ph[0] : ph[1];
    mx = mx > ph[2] ? mx : ph[2];
    mn = ph[0] < ph[1] ? ph[0] : ph[1];
    mn = mn < ph[2] ? mn : ph[2];
    case (sch)
      SCH_SPWM:  off = HalfQ;
      SCH_SVPWM: off = HalfQ - halve(mx + mn);
      SCH_CMAX:  off = OneQ - mx;
      SCH_CMIN:  off = -mn;
      SCH_DPWM1: off = (mx + mn >= 0) ? OneQ - mx : -mn;
      default:   off = clamp_top_rotated(al, be, sch) ? OneQ - mx : -mn;
    endcase
    r.a = DutyW'(clip_duty(ph[0] + off));
    r.b = DutyW'(clip_duty(ph[1] + off));
    r.c = DutyW'(clip_duty(ph[2] + off));
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // Compare each accepted duty set with the oldest prediction
  initial begin
    duty_set_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        n_duties++;
        if (duty_fifo.size() == 0) begin
          report_mismatch("unexpected duty set", 1, 0);
        end else begin
          want = duty_fifo.pop_front();
          if (phase_a_duty_o !== want.a) report_mismatch("phase a", phase_a_duty_o, want.a);
          if (phase_b_duty_o !== want.b) report_mismatch("phase b", phase_b_duty_o, want.b);
          if (phase_c_duty_o !== want.c) report_mismatch("phase c", phase_c_duty_o, want.c);
        end
      end
    end
  end

  // Random receiver back-pressure
  initial begin
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one request, with a random gap first; hold until taken
  task automatic send_vector(logic signed [VoltW-1:0] va, logic signed [VoltW-1:0] vb,
                             logic [BusW-1:0] bus);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    volt_alpha_i  <= va;
    volt_beta_i   <= vb;
    bus_voltage_i <= bus;
    do @(posedge clk_i); while (in_stall_o);
    duty_fifo.push_back(predict_duties(va, vb, bus, scheme_q));
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (duty_fifo.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic write_scheme(scheme_e sch);
    drain_pipeline();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sch;
    do @(posedge clk_i); while (!cfg_ready_o);
    scheme_q = sch;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Field extremes, zero bus, overmodulation, under the reset scheme
  task automatic test_directed_edges();
    send_vector(16'sh0000, 16'sh0000, 15'd1);
    send_vector(16'sh7FFF, 16'sh7FFF, 15'd1);
    send_vector(16'sh8000, 16'sh8000, 15'd1);
    send_vector(16'sh7FFF, 16'sh8000, 15'h7FFF);
    send_vector(16'sh8000, 16'sh7FFF, 15'h7FFF);
    send_vector(16'sh1000, -16'sh1000, 15'd0);
    send_vector(16'sd1000, 16'sd0, 15'd2000);
    send_vector(-16'sd1000, 16'sd577, 15'd2000);
    send_vector(16'sd5000, 16'sd5000, 15'd3000);
    send_vector(16'sd0, -16'sd1, 15'd2);
  endtask

  // Every scheme on two vectors, stepping the register from 7 down to 0
  task automatic test_each_scheme();
    scheme_e sch;
    for (int s = 7; s >= 0; s--) begin
      sch = scheme_e'(s);
      write_scheme(sch);
      send_vector(16'sd1200, 16'sd300, 15'd2000);
      send_vector(-16'sd400, -16'sd1100, 15'd2000);
    end
  endtask

  // Mostly in-range vectors, some overmodulated, a few on the rails
  task automatic random_vector(output logic signed [VoltW-1:0] va,
                               output logic signed [VoltW-1:0] vb,
                               output logic [BusW-1:0] bus);
    int sel;
    sel = $urandom_range(9);
    va  = VoltW'($urandom);
    vb  = VoltW'($urandom);
    bus = BusW'($urandom);
    if (sel < 6) begin
      bus = BusW'($urandom_range(32767, 100));
      va  = VoltW'($signed($urandom_range(2 * bus)) - $signed({17'd0, bus}));
      vb  = VoltW'($signed($urandom_range(2 * bus)) - $signed({17'd0, bus}));
    end else if (sel == 6) begin
      bus = BusW'($urandom_range(5));
    end
  endtask

  task automatic test_random_traffic(int n_items, int s_pct, int r_pct);
    logic signed [VoltW-1:0] va;
    logic signed [VoltW-1:0] vb;
    logic [BusW-1:0]         bus;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 120 == 0) write_scheme(scheme_e'($urandom_range(7)));
      random_vector(va, vb, bus);
      send_vector(va, vb, bus);
    end
  endtask

  initial begin
    n_errors = 0;
    n_duties = 0;
    send_idle_pct = 20;
    recv_idle_pct = 47;
    scheme_q = SchemeRst;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_edges();
    test_each_scheme();
    test_random_traffic(460, 20, 47);
    test_random_traffic(460, 47, 20);
    test_random_traffic(460, 0, 0);
    drain_pipeline();
    $display("Covered all eight schemes, field extremes and a zero bus; %0d duty sets checked.",
             n_duties);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/tpwm_pkg.sv
hw/rtl/tpwm_div.sv
hw/rtl/three_phase_pwm_duty_modulator_top.sv
sim/tb.sv
